// ===== rtl/nfba_pkg.sv =====
// Package for the next-fit bitmap block allocator.
// Holds the request/result structs, status codes and fixed sizes.
// No dependencies.
package nfba_pkg;

  localparam int unsigned MAX_BLOCKS      = 4096;
  localparam int unsigned MAX_RUN         = 4;
  localparam int unsigned RESERVED_BLOCKS = 1;

  localparam int unsigned ADDR_W = 12;  // bitmap address
  localparam int unsigned CNT_W  = 13;  // block counts, reaches MAX_BLOCKS
  localparam int unsigned LEN_W  = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RUN   = 2'd1,
    ST_BAD_ARG  = 2'd2,
    ST_DBL_FREE = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic              req_type;
    logic [LEN_W-1:0]  run_length;
    logic [ADDR_W-1:0] rel_block;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] first_block;
  } res_t;

endpackage

// ===== rtl/next_fit_bitmap_block_allocator.sv =====
// Next-fit bitmap block allocator, top level.
// A free reads its bit and clears it in S_FREE; a bad request is answered from S_IDLE;
// an allocate scans in S_SCAN, then sets the run in S_MARK. One request at a time; the
// scan reads one bitmap bit per cycle from a one-read one-write 4096 x 1 memory.
// Reset: synchronous, active low; then clears all 4096 bitmap bits (busy high).
// The result strobe cannot be stalled; busy is the only back-pressure.
module next_fit_bitmap_block_allocator
  import nfba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  req_t             in_req,
  // result channel
  output logic             out_valid,
  output res_t             out_res,
  // total_blocks register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FREE  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_MARK  = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] NB_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] RSV    = CNT_W'(RESERVED_BLOCKS);
  localparam logic [LEN_W-1:0] LEN_MX = LEN_W'(MAX_RUN);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] hint_r, hint_nxt;
  logic [CNT_W-1:0] q_r, q_nxt;        // next bit to read
  logic [CNT_W-1:0] pq_r, pq_nxt;      // bit whose data is in rd_q
  logic             pend_r, pend_nxt;  // rd_q holds a scan bit
  logic [CNT_W-1:0] hi_r, hi_nxt;      // pass end, exclusive
  logic [CNT_W-1:0] end1_r, end1_nxt;  // second pass end
  logic             pass_r, pass_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;    // consecutive free bits seen
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] mark_r, mark_nxt;  // bitmap write pointer (also clear pointer)
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  // bitmap memory, registered read
  logic             mem [MAX_BLOCKS];
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic             rd_q, we, wd;

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wd;
    end
  end

  logic [CNT_W-1:0] nb;
  logic [CNT_W-1:0] blk_w, start_w, end1_w, p_w, hint_new;
  logic [LEN_W-1:0] run_c;

  assign nb      = (total_r < NB_MAX) ? total_r : NB_MAX;
  assign blk_w   = {1'b0, in_req.rel_block};
  assign start_w = (hint_r < RSV || hint_r >= nb) ? RSV : hint_r;
  assign end1_w  = ((hint_r < nb ? hint_r : nb) <= RSV) ? nb : (hint_r < nb ? hint_r : nb);
  assign run_c   = rd_q ? '0 : cnt_r + LEN_W'(1);
  assign p_w     = pq_r - {{(CNT_W-LEN_W){1'b0}}, len_r} + CNT_W'(1);
  assign hint_new = first_r + {{(CNT_W-LEN_W){1'b0}}, len_r};

  always_comb begin
    state_nxt     = state_r;
    hint_nxt      = hint_r;
    q_nxt         = q_r;
    pq_nxt        = pq_r;
    pend_nxt      = 1'b0;
    hi_nxt        = hi_r;
    end1_nxt      = end1_r;
    pass_nxt      = pass_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    first_nxt     = first_r;
    mark_nxt      = mark_r;
    blk_nxt       = blk_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    rd_addr       = q_r[ADDR_W-1:0];
    wr_addr       = mark_r[ADDR_W-1:0];
    we            = 1'b0;
    wd            = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        mark_nxt = mark_r + CNT_W'(1);
        if (mark_r == NB_MAX - CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = in_req.rel_block;
        if (start) begin
          out_res_nxt.first_block = '0;
          if (in_req.req_type == REQ_FREE) begin
            if (blk_w < RSV || blk_w >= nb) begin
              out_valid_nxt      = 1'b1;
              out_res_nxt.status = ST_BAD_ARG;
            end else begin
              blk_nxt   = in_req.rel_block;
              state_nxt = S_FREE;
            end
          end else if (in_req.run_length == '0 || in_req.run_length > LEN_MX) begin
            out_valid_nxt      = 1'b1;
            out_res_nxt.status = ST_BAD_ARG;
          end else if (nb <= RSV ||
                       {{(CNT_W-LEN_W){1'b0}}, in_req.run_length} > nb - RSV) begin
            out_valid_nxt      = 1'b1;
            out_res_nxt.status = ST_NO_RUN;
          end else begin
            len_nxt   = in_req.run_length;
            q_nxt     = start_w;
            hi_nxt    = nb;
            end1_nxt  = end1_w;
            pass_nxt  = 1'b0;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_FREE: begin
        wr_addr            = blk_r;
        out_valid_nxt      = 1'b1;
        out_res_nxt.status = rd_q ? ST_OK : ST_DBL_FREE;
        we                 = rd_q;
        state_nxt          = S_IDLE;
      end
      S_SCAN: begin
        // issue the next read while the previous bit is checked
        if (q_r < hi_r) begin
          pend_nxt = 1'b1;
          pq_nxt   = q_r;
          q_nxt    = q_r + CNT_W'(1);
        end
        if (pend_r) begin
          cnt_nxt = run_c;
          if (run_c == len_r) begin
            first_nxt = p_w;
            mark_nxt  = p_w;
            cnt_nxt   = '0;
            state_nxt = S_MARK;
          end
        end else if (q_r >= hi_r) begin
          // pass exhausted
          if (!pass_r) begin
            pass_nxt = 1'b1;
            q_nxt    = RSV;
            hi_nxt   = end1_r;
            cnt_nxt  = '0;
          end else begin
            out_valid_nxt           = 1'b1;
            out_res_nxt.status      = ST_NO_RUN;
            out_res_nxt.first_block = '0;
            state_nxt               = S_IDLE;
          end
        end
      end
      S_MARK: begin
        we       = 1'b1;
        wd       = 1'b1;
        mark_nxt = mark_r + CNT_W'(1);
        cnt_nxt  = cnt_r + LEN_W'(1);
        if (cnt_r + LEN_W'(1) == len_r) begin
          hint_nxt                = (hint_new >= nb) ? RSV : hint_new;
          out_valid_nxt           = 1'b1;
          out_res_nxt.status      = ST_OK;
          out_res_nxt.first_block = first_r[ADDR_W-1:0];
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      total_r     <= NB_MAX;
      hint_r      <= RSV;
      mark_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      mark_r      <= mark_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        total_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    pq_r      <= pq_nxt;
    hi_r      <= hi_nxt;
    end1_r    <= end1_nxt;
    pass_r    <= pass_nxt;
    cnt_r     <= cnt_nxt;
    len_r     <= len_nxt;
    first_r   <= first_nxt;
    blk_r     <= blk_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  // block count only changes between requests
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // failed or free results never carry a block
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_OK |-> out_res.first_block == '0)
    else $error("nonzero first_block on failed request");

  // a request is never taken while the bitmap is being cleared
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> busy)
    else $error("not busy during clear");

  // marking always ends in a successful result
  a_mark_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK && state_nxt == S_IDLE |=> out_valid && out_res.status == ST_OK)
    else $error("mark did not produce ok result");

endmodule
